### hdl/bcp_pkg.sv
package bcp_pkg;

   localparam int MAX_BOXES  = 64;
   localparam int COORD_BITS = 16;

   // fixed by the field list
   localparam int INDEX_BITS  = 6;
   localparam int COUNT_BITS  = 7;
   localparam int MARGIN_BITS = 15;
   localparam int CSR_BITS    = 15;

   localparam int ADDR_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_BOXES + 1);
   // edge +/- margin never overflows at this width
   localparam int SUM_BITS  =
      ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 2;
   localparam int BOX_BITS  = 4 * COORD_BITS;

   localparam logic [COUNT_BITS-1:0] EDGE_MARGIN_RESET = COUNT_BITS'(0) | 7'd0;
   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(26);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic CSR_ACTIVE_BOXES = 1'b0;
   localparam logic CSR_EDGE_MARGIN  = 1'b1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] left;
      logic signed [COORD_BITS-1:0] bottom;
      logic signed [COORD_BITS-1:0] right;
      logic signed [COORD_BITS-1:0] top;
   } box_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

endpackage

### hdl/bcp_ram.sv
module bcp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hdl/bcp_overlap.sv
module bcp_overlap
   import bcp_pkg::*;
(
   input  box_type                obstacle,
   input  box_type                mover,
   input  logic [MARGIN_BITS-1:0] margin,
   output logic                   blocks
);

   logic signed [SUM_BITS-1:0] l, bo, r, t;
   logic signed [SUM_BITS-1:0] ml, mb, mr, mt;
   logic signed [SUM_BITS-1:0] m;
   logic signed [SUM_BITS-1:0] l_lo, l_hi, r_lo, r_hi, bo_lo, bo_hi, t_hi;
   logic overlap, left_band, right_band, bottom_band;

   always_comb begin
      l  = SUM_BITS'(obstacle.left);
      bo = SUM_BITS'(obstacle.bottom);
      r  = SUM_BITS'(obstacle.right);
      t  = SUM_BITS'(obstacle.top);
      ml = SUM_BITS'(mover.left);
      mb = SUM_BITS'(mover.bottom);
      mr = SUM_BITS'(mover.right);
      mt = SUM_BITS'(mover.top);
      m  = $signed({{(SUM_BITS - MARGIN_BITS){1'b0}}, margin});

      l_lo  = l - m;
      l_hi  = l + m;
      r_lo  = r - m;
      r_hi  = r + m;
      bo_lo = bo - m;
      bo_hi = bo + m;
      t_hi  = t + m;

      overlap     = (mr >= l) && (r >= ml) && (mt >= bo) && (t >= mb);
      left_band   = (mr >= l_lo) && (mr <= l_hi) && (mb <= t_hi) && (mt >= bo_lo);
      right_band  = (ml >= r_lo) && (ml <= r_hi) && (mb <= t_hi) && (mt >= bo_lo);
      bottom_band = (mt >= bo_lo) && (mt <= bo_hi) && (mr >= l_lo) && (ml <= r_hi);

      blocks = overlap && !left_band && !right_band && !bottom_band;
   end

endmodule

### hdl/box_collision_permit_core.sv
// Obstacle table with a permit test for a mover box.
// Input: an item is taken at a clock edge with start high and busy low.
// req_command selects a table write or a mover query. A write stores the
// box_* edges at req_entry_index and answers allowed in the next cycle.
// A query walks entries 0 .. active_boxes-1 (held at the table size) and
// answers with the first blocking entry, or allowed when none blocks.
// Result: rsp_valid marks one cycle on rsp_move_allowed and
// rsp_blocking_index; the receiver cannot stall, so nothing is held back.
// A write, or a query with no entries, answers from idle without a walk;
// in a walk each entry passes the table read register, then the overlap
// check. The walk reads one entry per cycle from the single read port
// of the obstacle memory, so that port sets the query time; busy drops
// with the result and a new item may start in that cycle.
// Config: csr_valid/csr_ready with csr_index and csr_wdata, written only while idle
// by the user; the block does not enforce it. Reset clears the control state and
// sets active_boxes to 0 and edge_margin to 26; table contents are undefined until written.
module box_collision_permit_core
   import bcp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [INDEX_BITS-1:0]         req_entry_index,
   input  logic signed [COORD_BITS-1:0]  req_box_left,
   input  logic signed [COORD_BITS-1:0]  req_box_bottom,
   input  logic signed [COORD_BITS-1:0]  req_box_right,
   input  logic signed [COORD_BITS-1:0]  req_box_top,
   input  logic signed [COORD_BITS-1:0]  req_mover_left,
   input  logic signed [COORD_BITS-1:0]  req_mover_bottom,
   input  logic signed [COORD_BITS-1:0]  req_mover_right,
   input  logic signed [COORD_BITS-1:0]  req_mover_top,
   output logic                          rsp_valid,
   output logic                          rsp_move_allowed,
   output logic [INDEX_BITS-1:0]         rsp_blocking_index,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [CSR_BITS-1:0]           csr_wdata
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  active_boxes_ff;
   logic [MARGIN_BITS-1:0] edge_margin_ff;

   box_type               mover_ff, mover_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   issue_ff, issue_in;
   logic [ADDR_BITS-1:0]  chk_idx_ff, chk_idx_in;
   logic                  chk_vld_ff, chk_vld_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_allowed_ff, rsp_allowed_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;

   logic                  accept;
   logic                  in_range;
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   box_type               wr_box;
   logic [BOX_BITS-1:0]   ram_rdata;
   box_type               rd_box;
   logic                  blocks;
   logic                  issue_more;
   logic [CNT_BITS:0]     active_ext;
   logic [CNT_BITS-1:0]   count_sat;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign in_range  = ({{(CNT_BITS + 1){1'b0}}, req_entry_index} <
                       (CNT_BITS + 1 + INDEX_BITS)'(MAX_BOXES));
   assign ram_we    = accept && (req_command == CMD_WRITE) && in_range;
   assign ram_waddr = ADDR_BITS'(req_entry_index);
   assign wr_box    = '{left: req_box_left, bottom: req_box_bottom,
                        right: req_box_right, top: req_box_top};
   assign rd_box    = box_type'(ram_rdata);

   // hold the count at the table size
   assign active_ext = (CNT_BITS + 1)'(active_boxes_ff);
   assign count_sat  = (active_ext > (CNT_BITS + 1)'(MAX_BOXES)) ?
                       CNT_BITS'(MAX_BOXES) : CNT_BITS'(active_boxes_ff);

   assign issue_more = (issue_ff < count_ff);

   bcp_ram #(
      .WIDTH (BOX_BITS),
      .DEPTH (MAX_BOXES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_box),
      .raddr (issue_ff[ADDR_BITS-1:0]),
      .rdata (ram_rdata)
   );

   bcp_overlap u_overlap (
      .obstacle (rd_box),
      .mover    (mover_ff),
      .margin   (edge_margin_ff),
      .blocks   (blocks)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         chk_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         active_boxes_ff <= '0;
         edge_margin_ff  <= MARGIN_RESET;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACTIVE_BOXES: active_boxes_ff <= csr_wdata[COUNT_BITS-1:0];
               CSR_EDGE_MARGIN:  edge_margin_ff  <= csr_wdata[MARGIN_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      mover_ff       <= mover_in;
      count_ff       <= count_in;
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_index_ff   <= rsp_index_in;
   end

   always_comb begin
      state_in       = state_ff;
      mover_in       = mover_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      chk_idx_in     = chk_idx_ff;
      chk_vld_in     = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_index_in   = rsp_index_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_WRITE || count_sat == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_allowed_in = 1'b1;
                  rsp_index_in   = '0;
               end else begin
                  mover_in = '{left: req_mover_left, bottom: req_mover_bottom,
                               right: req_mover_right, top: req_mover_top};
                  count_in = count_sat;
                  issue_in = '0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // advance the read address while entries remain
            if (issue_more) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end
            chk_vld_in = issue_more;
            chk_idx_in = issue_ff[ADDR_BITS-1:0];
            if (chk_vld_ff && blocks) begin
               chk_vld_in     = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = 1'b0;
               rsp_index_in   = INDEX_BITS'(chk_idx_ff);
               state_in       = ST_IDLE;
            end else if (chk_vld_ff &&
                         ((CNT_BITS + 1)'(chk_idx_ff) + (CNT_BITS + 1)'(1) ==
                          (CNT_BITS + 1)'(count_ff))) begin
               chk_vld_in     = 1'b0;
               rsp_valid_in   = 1'b1;
               rsp_allowed_in = 1'b1;
               rsp_index_in   = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_move_allowed   = rsp_allowed_ff;
   assign rsp_blocking_index = rsp_index_ff;

endmodule

### sim/bcp_checker.sv
module bcp_checker
   import bcp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_command,
   input  logic [INDEX_BITS-1:0]         req_entry_index,
   input  logic signed [COORD_BITS-1:0]  req_box_left,
   input  logic signed [COORD_BITS-1:0]  req_box_bottom,
   input  logic signed [COORD_BITS-1:0]  req_box_right,
   input  logic signed [COORD_BITS-1:0]  req_box_top,
   input  logic signed [COORD_BITS-1:0]  req_mover_left,
   input  logic signed [COORD_BITS-1:0]  req_mover_bottom,
   input  logic signed [COORD_BITS-1:0]  req_mover_right,
   input  logic signed [COORD_BITS-1:0]  req_mover_top,
   input  logic                          rsp_valid,
   input  logic                          rsp_move_allowed,
   input  logic [INDEX_BITS-1:0]         rsp_blocking_index,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [CSR_BITS-1:0]           csr_wdata,
   output int                            fail_count,
   output int                            pending
);

   typedef struct packed {
      logic                  allowed;
      logic [INDEX_BITS-1:0] index;
   } permit_type;

   box_type                obstacles [MAX_BOXES];
   logic [COUNT_BITS-1:0]  active_count;
   logic [MARGIN_BITS-1:0] margin;
   permit_type             permits_due [$];
   int                     failures = 0;

   function automatic logic obstacle_blocks(box_type ob, box_type mv, int m);
      int l, bo, r, t, ml, mb, mr, mt;
      l  = ob.left;
      bo = ob.bottom;
      r  = ob.right;
      t  = ob.top;
      ml = mv.left;
      mb = mv.bottom;
      mr = mv.right;
      mt = mv.top;
      if (!(mr >= l && r >= ml && mt >= bo && t >= mb))
         return 1'b0;
      // tolerance bands about the left, right and bottom edges; the top has none
      if (mr >= l - m && mr <= l + m && mb <= t + m && mt >= bo - m)
         return 1'b0;
      if (ml >= r - m && ml <= r + m && mb <= t + m && mt >= bo - m)
         return 1'b0;
      if (mt >= bo - m && mt <= bo + m && mr >= l - m && ml <= r + m)
         return 1'b0;
      return 1'b1;
   endfunction

   function automatic permit_type permit_for(box_type mv);
      int         n;
      permit_type p;
      n = (active_count > MAX_BOXES) ? MAX_BOXES : int'(active_count);
      p.allowed = 1'b1;
      p.index = '0;
      for (int i = 0; i < n; i++) begin
         if (obstacle_blocks(obstacles[i], mv, int'(margin))) begin
            p.allowed = 1'b0;
            p.index = INDEX_BITS'(i);
            return p;
         end
      end
      return p;
   endfunction

   task automatic report_mismatch(input string what);
      failures++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin : watch
      permit_type got, want;
      box_type    mv;
      if (reset) begin
         active_count = '0;
         margin = MARGIN_RESET;
         permits_due.delete();
      end else begin
         // retire the oldest transaction before taking a new one in the same cycle
         if (rsp_valid) begin
            got.allowed = rsp_move_allowed;
            got.index = rsp_blocking_index;
            if (permits_due.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = permits_due.pop_front();
               if (got.allowed !== want.allowed)
                  report_mismatch($sformatf("move_allowed %b, want %b",
                                            got.allowed, want.allowed));
               if (got.index !== want.index)
                  report_mismatch($sformatf("blocking_index %0d, want %0d",
                                            got.index, want.index));
            end
         end
         if (start && !busy) begin
            if (req_command == CMD_WRITE) begin
               obstacles[req_entry_index] =
                  '{req_box_left, req_box_bottom, req_box_right, req_box_top};
               permits_due.push_back(permit_type'{allowed: 1'b1, index: '0});
            end else begin
               mv = '{req_mover_left, req_mover_bottom, req_mover_right, req_mover_top};
               permits_due.push_back(permit_for(mv));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ACTIVE_BOXES)
               active_count = csr_wdata[COUNT_BITS-1:0];
            else
               margin = csr_wdata[MARGIN_BITS-1:0];
         end
      end
      pending <= permits_due.size();
      fail_count <= failures;
   end

endmodule

### sim/tb.sv
module tb;
   import bcp_pkg::*;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_command;
   logic [INDEX_BITS-1:0]         req_entry_index;
   logic signed [COORD_BITS-1:0]  req_box_left;
   logic signed [COORD_BITS-1:0]  req_box_bottom;
   logic signed [COORD_BITS-1:0]  req_box_right;
   logic signed [COORD_BITS-1:0]  req_box_top;
   logic signed [COORD_BITS-1:0]  req_mover_left;
   logic signed [COORD_BITS-1:0]  req_mover_bottom;
   logic signed [COORD_BITS-1:0]  req_mover_right;
   logic signed [COORD_BITS-1:0]  req_mover_top;
   logic                          rsp_valid;
   logic                          rsp_move_allowed;
   logic [INDEX_BITS-1:0]         rsp_blocking_index;
   logic                          csr_valid;
   logic                          csr_ready;
   logic                          csr_index;
   logic [CSR_BITS-1:0]           csr_wdata;
   int                            fail_count;
   int                            pending;

   box_type layout [MAX_BOXES];
   int      margin_now;
   int      active_now;
   bit      start_up;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   box_collision_permit_core dut (.*);

   bcp_checker permit_check (.*);

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic logic signed [COORD_BITS-1:0] fit(int v);
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic box_type make_box(int l, int b, int r, int t);
      box_type bx;
      bx.left = fit(l);
      bx.bottom = fit(b);
      bx.right = fit(r);
      bx.top = fit(t);
      return bx;
   endfunction

   function automatic int extreme();
      return $urandom_range(1, 0) ? 32767 : -32768;
   endfunction

   function automatic box_type random_obstacle();
      int k, l, b;
      k = $urandom_range(99, 0);
      if (k < 10)
         return box_type'({$urandom(), $urandom()});
      if (k < 14)
         return make_box(extreme(), extreme(), extreme(), extreme());
      // keep most boxes small and scattered so that walks go deep
      l = pick(-16384, 14336);
      b = pick(-16384, 14336);
      return make_box(l, b, l + pick(16, 2048), b + pick(16, 2048));
   endfunction

   function automatic box_type mover_near(box_type ob);
      int l, b, r, t, m, off, wx, wy, ml, mb, mr, mt;
      l = ob.left;
      b = ob.bottom;
      r = ob.right;
      t = ob.top;
      m = margin_now;
      off = pick(-m - 3, m + 3);
      wx = pick(0, 1024);
      wy = pick(0, 1024);
      ml = pick(l - 256, l + 512);
      mb = pick(b - 256, b + 512);
      mr = ml + wx;
      mt = mb + wy;
      case ($urandom_range(4, 0))
         1: begin
            mr = l + off;
            ml = mr - wx;
         end
         2: begin
            ml = r + off;
            mr = ml + wx;
         end
         3: begin
            mt = b + off;
            mb = mt - wy;
         end
         4: begin
            mb = t + off;
            mt = mb + wy;
         end
         default: ;
      endcase
      return make_box(ml, mb, mr, mt);
   endfunction

   function automatic box_type random_mover();
      int n, k, l, b;
      n = (active_now > MAX_BOXES) ? MAX_BOXES : active_now;
      k = $urandom_range(99, 0);
      if (k < 70)
         return mover_near(layout[(n > 0) ? $urandom_range(n - 1, 0) : $urandom_range(63, 0)]);
      if (k < 85)
         return box_type'({$urandom(), $urandom()});
      l = pick(-16384, 14336);
      b = pick(-16384, 14336);
      return make_box(l, b, l + pick(0, 2048), b + pick(0, 2048));
   endfunction

   // hold start high from one transaction to the next unless the sender idles
   task automatic send(input logic cmd, input logic [INDEX_BITS-1:0] idx,
                       input box_type bx, input int idle_pct);
      while ($urandom_range(99, 0) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
         start_up = 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_command <= cmd;
      if (cmd == CMD_WRITE) begin
         req_entry_index <= idx;
         {req_box_left, req_box_bottom, req_box_right, req_box_top} <= bx;
         {req_mover_left, req_mover_bottom, req_mover_right, req_mover_top} <=
            {$urandom(), $urandom()};
         layout[idx] = bx;
      end else begin
         req_entry_index <= INDEX_BITS'($urandom());
         {req_box_left, req_box_bottom, req_box_right, req_box_top} <=
            {$urandom(), $urandom()};
         {req_mover_left, req_mover_bottom, req_mover_right, req_mover_top} <= bx;
      end
      do @(posedge clock); while (busy);
      start_up = 1'b1;
   endtask

   task automatic settle();
      if (start_up) begin
         @(negedge clock);
         start <= 1'b0;
         start_up = 1'b0;
      end
      while (pending != 0 || busy)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ACTIVE_BOXES)
         active_now = value & 127;
      else
         margin_now = value & 32767;
   endtask

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int margin_plan [9];
      int count_plan [9];
      int idle_plan [3];
      int pct;
      margin_plan = '{26, 0, 32767, 5, 200, 1, 26, 1000, 60};
      count_plan = '{64, 127, 1, 0, 64, 100, 8, 64, 65};
      idle_plan = '{0, 60, 9};
      margin_plan[3] = $urandom_range(63, 0);
      margin_plan[8] = $urandom_range(32767, 0);
      count_plan[7] = $urandom_range(127, 1);
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_WRITE;
      req_entry_index = '0;
      {req_box_left, req_box_bottom, req_box_right, req_box_top} = '0;
      {req_mover_left, req_mover_bottom, req_mover_right, req_mover_top} = '0;
      csr_valid = 1'b0;
      csr_index = CSR_ACTIVE_BOXES;
      csr_wdata = '0;
      start_up = 1'b0;
      margin_now = 26;
      active_now = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty walk, then a plain box, an inverted one, a small one, the full plane and an inverted last entry
      send(CMD_QUERY, '0, make_box(-32768, -32768, 32767, 32767), 0);
      send(CMD_WRITE, INDEX_BITS'(0), make_box(0, 0, 1000, 1000), 0);
      send(CMD_WRITE, INDEX_BITS'(1), make_box(1000, 1000, 0, 0), 0);
      send(CMD_WRITE, INDEX_BITS'(2), make_box(-500, -500, -100, -100), 0);
      send(CMD_WRITE, INDEX_BITS'(3), make_box(-32768, -32768, 32767, 32767), 0);
      send(CMD_WRITE, INDEX_BITS'(63), make_box(32767, 32767, -32768, -32768), 0);
      write_csr(CSR_ACTIVE_BOXES, 4);
      send(CMD_QUERY, '0, make_box(400, 400, 600, 600), 0);
      send(CMD_QUERY, '0, make_box(-300, 400, 10, 600), 0);
      send(CMD_QUERY, '0, make_box(990, 200, 1500, 300), 0);
      send(CMD_QUERY, '0, make_box(200, -400, 300, 20), 0);
      send(CMD_QUERY, '0, make_box(200, 1000, 300, 1400), 0);
      send(CMD_QUERY, '0, make_box(-300, 400, 27, 600), 0);
      send(CMD_QUERY, '0, make_box(-32768, 5000, -32760, 6000), 0);
      send(CMD_QUERY, '0, make_box(600, 600, 400, 400), 0);
      write_csr(CSR_EDGE_MARGIN, 0);
      send(CMD_QUERY, '0, make_box(-300, 400, 0, 600), 0);
      send(CMD_QUERY, '0, make_box(0, 0, 0, 0), 0);
      write_csr(CSR_EDGE_MARGIN, 32767);
      send(CMD_QUERY, '0, make_box(400, 400, 600, 600), 0);
      send(CMD_QUERY, '0, make_box(32767, 32767, 32767, 32767), 0);

      // fill the whole table before any walk may reach past entry 3
      for (int e = 0; e < MAX_BOXES; e++)
         send(CMD_WRITE, INDEX_BITS'(e), random_obstacle(), 0);

      for (int p = 0; p < 9; p++) begin
         write_csr(CSR_EDGE_MARGIN, margin_plan[p]);
         write_csr(CSR_ACTIVE_BOXES, count_plan[p]);
         for (int k = 0; k < 150; k++) begin
            pct = ((k / 25) % 4 == 3) ? 0 : idle_plan[p % 3];
            if ($urandom_range(99, 0) < 20)
               send(CMD_WRITE, INDEX_BITS'($urandom_range(63, 0)), random_obstacle(), pct);
            else
               send(CMD_QUERY, '0, random_mover(), pct);
         end
      end

      settle();
      repeat (70) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### box_collision_permit_core.f
hdl/bcp_pkg.sv
hdl/bcp_ram.sv
hdl/bcp_overlap.sv
hdl/box_collision_permit_core.sv
sim/bcp_checker.sv
sim/tb.sv
